>>> src/lee_pkg.sv
// Shared types and codes for the Lorenz Euler step block.
// Used by lee_csr, lee_ctrl, lee_dp and lorenz_euler_step.
package lee_pkg;

   localparam int AddrWidth = 5;

   localparam logic [2:0] REG_SIGMA = 3'd0;
   localparam logic [2:0] REG_RHO   = 3'd1;
   localparam logic [2:0] REG_BETA  = 3'd2;
   localparam logic [2:0] REG_DT    = 3'd3;
   localparam logic [2:0] REG_INITX = 3'd4;
   localparam logic [2:0] REG_INITY = 3'd5;
   localparam logic [2:0] REG_INITZ = 3'd6;

   localparam logic [3:0] MUL_VX = 4'd0;
   localparam logic [3:0] MUL_XR = 4'd1;
   localparam logic [3:0] MUL_XZ = 4'd2;
   localparam logic [3:0] MUL_XY = 4'd3;
   localparam logic [3:0] MUL_BZ = 4'd4;
   localparam logic [3:0] MUL_DX = 4'd5;
   localparam logic [3:0] MUL_DY = 4'd6;
   localparam logic [3:0] MUL_DZ = 4'd7;
   localparam logic [3:0] MUL_SX = 4'd8;
   localparam logic [3:0] MUL_SY = 4'd9;
   localparam logic [3:0] MUL_SZ = 4'd10;

   typedef struct packed {
      logic signed [31:0] sigma;
      logic signed [31:0] rho;
      logic signed [31:0] beta;
      logic [15:0]        dt;
      logic signed [31:0] init_x;
      logic signed [31:0] init_y;
      logic signed [31:0] init_z;
   } cfg_type;

   typedef struct packed {
      logic       capture;
      logic [3:0] mul_sel;
      logic       use_en;
      logic [3:0] use_sel;
      logic       sqrt_init;
      logic       sqrt_step;
      logic       out_load;
   } cmd_type;

   typedef struct packed {
      logic out_busy;
   } sts_type;

endpackage

>>> src/lee_csr.sv
// Configuration registers of the Lorenz Euler step block, APB-style access.
// Depends on lee_pkg.
module lee_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [lee_pkg::AddrWidth-1:0] csr_paddr,
   input  logic [31:0]                   csr_pwdata,
   output logic [31:0]                   csr_prdata,
   output logic                          csr_pready,
   output lee_pkg::cfg_type              cfg
);
   import lee_pkg::*;

   cfg_type    cfg_ff;
   logic [2:0] idx;
   logic       wr;

   assign csr_pready = 1'b1;
   assign idx        = csr_paddr[4:2];
   assign wr         = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign cfg        = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sigma  <= 32'sd655360;
         cfg_ff.rho    <= 32'sd1835008;
         cfg_ff.beta   <= 32'sd174763;
         cfg_ff.dt     <= 16'd655;
         cfg_ff.init_x <= 32'sd65536;
         cfg_ff.init_y <= '0;
         cfg_ff.init_z <= '0;
      end else if (wr) begin
         case (idx)
            REG_SIGMA: cfg_ff.sigma  <= csr_pwdata;
            REG_RHO:   cfg_ff.rho    <= csr_pwdata;
            REG_BETA:  cfg_ff.beta   <= csr_pwdata;
            REG_DT:    cfg_ff.dt     <= csr_pwdata[15:0];
            REG_INITX: cfg_ff.init_x <= csr_pwdata;
            REG_INITY: cfg_ff.init_y <= csr_pwdata;
            REG_INITZ: cfg_ff.init_z <= csr_pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (idx)
         REG_SIGMA: csr_prdata = cfg_ff.sigma;
         REG_RHO:   csr_prdata = cfg_ff.rho;
         REG_BETA:  csr_prdata = cfg_ff.beta;
         REG_DT:    csr_prdata = {16'd0, cfg_ff.dt};
         REG_INITX: csr_prdata = cfg_ff.init_x;
         REG_INITY: csr_prdata = cfg_ff.init_y;
         REG_INITZ: csr_prdata = cfg_ff.init_z;
         default:   csr_prdata = '0;
      endcase
   end

endmodule

>>> src/lee_ctrl.sv
// Sequencer of the Lorenz Euler step block: multiply schedule, square root, output.
// Depends on lee_pkg.
module lee_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic              req_tuser,
   input  lee_pkg::sts_type  sts,
   output lee_pkg::cmd_type  cmd
);
   import lee_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_MUL  = 2'd1;
   localparam logic [1:0] ST_SQRT = 2'd2;
   localparam logic [1:0] ST_DONE = 2'd3;

   logic [1:0] state_ff, state_in;
   logic [5:0] cnt_ff, cnt_in;

   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      cmd           = '0;
      cmd.mul_sel   = cnt_ff[3:0];
      cmd.use_sel   = cnt_ff[3:0] - 4'd1;
      case (state_ff)
         ST_IDLE: begin
            cnt_in = '0;
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = req_tuser ? ST_DONE : ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.use_en = (cnt_ff != 6'd0);
            cnt_in     = cnt_ff + 6'd1;
            if (cnt_ff == 6'd11) begin
               cnt_in   = '0;
               state_in = ST_SQRT;
            end
         end
         ST_SQRT: begin
            cmd.sqrt_init = (cnt_ff == 6'd0);
            cmd.sqrt_step = (cnt_ff != 6'd0);
            cnt_in        = cnt_ff + 6'd1;
            if (cnt_ff == 6'd32) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!sts.out_busy) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

>>> src/lee_dp.sv
// Datapath of the Lorenz Euler step block: state, shared multiplier,
// bit-serial square root and output register. Depends on lee_pkg.
module lee_dp #(
   parameter int FRAC_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  lee_pkg::cfg_type  cfg,
   input  lee_pkg::cmd_type  cmd,
   output lee_pkg::sts_type  sts,
   input  logic [95:0]       req_tdata,
   input  logic              req_tuser,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [127:0]      rsp_tdata
);
   import lee_pkg::*;

   function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
      if (v > 66'sd2147483647)       sat32 = 32'sh7fffffff;
      else if (v < -66'sd2147483648) sat32 = 32'sh80000000;
      else                           sat32 = v[31:0];
   endfunction

   function automatic logic signed [65:0] ext(input logic signed [31:0] v);
      ext = {{34{v[31]}}, v};
   endfunction

   logic signed [31:0] x_ff, y_ff, z_ff, ox_ff, oy_ff, oz_ff;
   logic signed [31:0] vx_ff, vy_ff, vz_ff, t1_ff, t3_ff;
   logic signed [65:0] prod_ff;
   logic [63:0]        acc_ff, rad_ff;
   logic [33:0]        rem_ff;
   logic [31:0]        root_ff;
   logic               rsp_valid_ff;
   logic [127:0]       rsp_data_ff;

   logic signed [32:0] opa, opb;
   logic signed [31:0] q, dyx;
   logic [35:0]        rem_try, trial;
   logic [30:0]        speed;

   assign q       = sat32(prod_ff >>> FRAC_BITS);
   assign dyx     = sat32(ext(y_ff) - ext(x_ff));
   assign rem_try = {rem_ff, rad_ff[63:62]};
   assign trial   = {2'b00, root_ff, 2'b01};
   assign speed   = root_ff[31] ? 31'h7fffffff : root_ff[30:0];

   always_comb begin
      case (cmd.mul_sel)
         MUL_VX:  begin opa = {cfg.sigma[31], cfg.sigma}; opb = {dyx[31], dyx}; end
         MUL_XR:  begin opa = {x_ff[31], x_ff}; opb = {cfg.rho[31], cfg.rho}; end
         MUL_XZ:  begin opa = {x_ff[31], x_ff}; opb = {z_ff[31], z_ff}; end
         MUL_XY:  begin opa = {x_ff[31], x_ff}; opb = {y_ff[31], y_ff}; end
         MUL_BZ:  begin opa = {cfg.beta[31], cfg.beta}; opb = {z_ff[31], z_ff}; end
         MUL_DX:  begin opa = {17'd0, cfg.dt}; opb = {vx_ff[31], vx_ff}; end
         MUL_DY:  begin opa = {17'd0, cfg.dt}; opb = {vy_ff[31], vy_ff}; end
         MUL_DZ:  begin opa = {17'd0, cfg.dt}; opb = {vz_ff[31], vz_ff}; end
         MUL_SX:  begin opa = {vx_ff[31], vx_ff}; opb = {vx_ff[31], vx_ff}; end
         MUL_SY:  begin opa = {vy_ff[31], vy_ff}; opb = {vy_ff[31], vy_ff}; end
         MUL_SZ:  begin opa = {vz_ff[31], vz_ff}; opb = {vz_ff[31], vz_ff}; end
         default: begin opa = '0; opb = '0; end
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= 66'(opa) * 66'(opb);
      if (cmd.capture) begin
         ox_ff  <= req_tdata[31:0];
         oy_ff  <= req_tdata[63:32];
         oz_ff  <= req_tdata[95:64];
         acc_ff <= '0;
      end
      if (cmd.use_en) begin
         case (cmd.use_sel)
            MUL_VX: vx_ff <= q;
            MUL_XR: t1_ff <= q;
            MUL_XZ: vy_ff <= sat32(ext(t1_ff) - ext(q) - ext(y_ff));
            MUL_XY: t3_ff <= q;
            MUL_BZ: vz_ff <= sat32(ext(t3_ff) - ext(q));
            MUL_SX, MUL_SY, MUL_SZ: acc_ff <= acc_ff + prod_ff[63:0];
            default: ;
         endcase
      end
      if (cmd.sqrt_init) begin
         rad_ff <= acc_ff;
      end else if (cmd.sqrt_step) begin
         rad_ff <= {rad_ff[61:0], 2'b00};
      end
      if (cmd.out_load) rsp_data_ff <= {1'b0, speed, z_ff, y_ff, x_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_ff         <= '0;
         y_ff         <= '0;
         z_ff         <= '0;
         rem_ff       <= '0;
         root_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.capture && req_tuser) begin
            x_ff    <= cfg.init_x;
            y_ff    <= cfg.init_y;
            z_ff    <= cfg.init_z;
            root_ff <= '0;
         end
         if (cmd.use_en) begin
            case (cmd.use_sel)
               MUL_DX: x_ff <= sat32(ext(x_ff) + ext(q) + ext(ox_ff));
               MUL_DY: y_ff <= sat32(ext(y_ff) + ext(q) + ext(oy_ff));
               MUL_DZ: z_ff <= sat32(ext(z_ff) + ext(q) + ext(oz_ff));
               default: ;
            endcase
         end
         if (cmd.sqrt_init) begin
            rem_ff  <= '0;
            root_ff <= '0;
         end else if (cmd.sqrt_step) begin
            if (rem_try >= trial) begin
               rem_ff  <= 34'(rem_try - trial);
               root_ff <= {root_ff[30:0], 1'b1};
            end else begin
               rem_ff  <= rem_try[33:0];
               root_ff <= {root_ff[30:0], 1'b0};
            end
         end
         if (cmd.out_load)          rsp_valid_ff <= 1'b1;
         else if (rsp_tready)       rsp_valid_ff <= 1'b0;
      end
   end

   assign sts.out_busy = rsp_valid_ff & ~rsp_tready;
   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_data_ff;

endmodule

>>> src/lorenz_euler_step.sv
// Lorenz system forward Euler step, signed fixed point with saturation.
// A load word passes straight to the output stage; a step word first runs
// eleven products through one shared 33x33 multiplier, then a one-bit-per-cycle
// square root over the 64-bit sum of squares.
// One word is in work at a time; the result register lets the next word in
// while a result waits. Depends on lee_pkg, lee_csr, lee_ctrl and lee_dp.
module lorenz_euler_step #(
   parameter int FRAC_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [95:0]                   req_tdata,  // offset_x, offset_y, offset_z
   input  logic                          req_tuser,  // operation
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [127:0]                  rsp_tdata,  // pos_x, pos_y, pos_z, speed, pad
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [lee_pkg::AddrWidth-1:0] csr_paddr,
   input  logic [31:0]                   csr_pwdata,
   output logic [31:0]                   csr_prdata,
   output logic                          csr_pready
);
   import lee_pkg::*;

   cfg_type cfg;
   cmd_type cmd;
   sts_type sts;

   lee_csr u_csr (
      .clock, .reset, .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr,
      .csr_pwdata, .csr_prdata, .csr_pready, .cfg
   );

   lee_ctrl u_ctrl (
      .clock, .reset, .req_tvalid, .req_tready, .req_tuser, .sts, .cmd
   );

   lee_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
      .clock, .reset, .cfg, .cmd, .sts, .req_tdata, .req_tuser,
      .rsp_tvalid, .rsp_tready, .rsp_tdata
   );

endmodule
